// ===== rtl/core/pnorm_pkg.sv =====
// Shared types and constants for the path normalizer.
`timescale 1ns / 1ps
`default_nettype none
package pnorm_pkg;

  localparam int unsigned CapWidth   = 13;
  localparam int unsigned ByteWidth  = 8;
  localparam logic [CapWidth-1:0] CapReset = CapWidth'(512);

  localparam logic [ByteWidth-1:0] ChSlash = 8'h2F;
  localparam logic [ByteWidth-1:0] ChDot   = 8'h2E;
  localparam logic [ByteWidth-1:0] ChSpace = 8'h20;
  localparam logic [ByteWidth-1:0] ChDel   = 8'h7F;
  localparam logic [ByteWidth-1:0] ChTerm  = 8'h00;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_INVALID   = 2'd1,
    ST_FORBIDDEN = 2'd2,
    ST_TOO_LONG  = 2'd3
  } status_t;

  // Per-path scan state.
  typedef struct packed {
    logic                skipping_leading;
    logic [1:0]          component_len;
    logic                prev_is_dot;
    logic                prev2_is_dot;
    logic [CapWidth-1:0] written_count;
    logic                discarding;
  } scan_state_t;

  // Scan state armed for a new path.
  localparam scan_state_t ScanRearm = '{
    skipping_leading: 1'b1,
    component_len:    2'd0,
    prev_is_dot:      1'b0,
    prev2_is_dot:     1'b0,
    written_count:    CapWidth'(0),
    discarding:       1'b0
  };

  // One result item.
  typedef struct packed {
    logic                 out_valid;
    logic [ByteWidth-1:0] out_byte;
    logic                 done_res;
    status_t              status;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/core/pnorm_step.sv =====
// Per-byte scan logic: next state and result for one input byte.
`timescale 1ns / 1ps
`default_nettype none
module pnorm_step
  import pnorm_pkg::*;
(
  input  wire scan_state_t          cur,
  input  wire logic [ByteWidth-1:0] byte_in,
  input  wire logic                 last_in,
  input  wire logic [CapWidth-1:0]  capacity,
  output scan_state_t               nxt,
  output result_t                   res
);

  scan_state_t rearm_state;
  logic        term;
  logic        dot_comp;
  logic        no_room;
  logic        err;
  status_t     err_status;
  logic        emit;
  logic [CapWidth:0] count_inc;

  always_comb begin
    rearm_state = '0;
    rearm_state.skipping_leading = 1'b1;
  end

  assign term      = (byte_in == ChTerm);
  assign dot_comp  = ((cur.component_len == 2'd1) && cur.prev_is_dot) ||
                     ((cur.component_len == 2'd2) && cur.prev_is_dot && cur.prev2_is_dot);
  assign count_inc = {1'b0, cur.written_count} + (CapWidth+1)'(1);
  assign no_room   = (count_inc >= {1'b0, capacity});

  always_comb begin
    nxt        = cur;
    res        = '0;
    err        = 1'b0;
    err_status = ST_OK;
    emit       = 1'b0;

    if (cur.discarding) begin
      // drop bytes until the end of the path
      if (term || last_in) nxt = rearm_state;
    end else if (term) begin
      res.done_res = 1'b1;
      priority if (cur.skipping_leading) res.status = ST_INVALID;
      else if (cur.component_len == 2'd0 || dot_comp) res.status = ST_FORBIDDEN;
      else res.status = ST_OK;
      nxt = rearm_state;
    end else begin
      if (byte_in == ChSlash) begin
        priority if (cur.skipping_leading || cur.component_len == 2'd0) begin
          // leading or repeated slash: nothing to emit
        end else if (dot_comp) begin
          err = 1'b1; err_status = ST_FORBIDDEN;
        end else if (no_room) begin
          err = 1'b1; err_status = ST_TOO_LONG;
        end else if (!last_in) begin
          emit = 1'b1;
          nxt.component_len = 2'd0;
          nxt.prev_is_dot   = 1'b0;
          nxt.prev2_is_dot  = 1'b0;
        end else begin
          // separator on the last byte: reported as a missing terminator below
        end
      end else if (byte_in < ChSpace || byte_in == ChDel) begin
        err = 1'b1; err_status = ST_INVALID;
      end else if (no_room) begin
        err = 1'b1; err_status = ST_TOO_LONG;
      end else if (!last_in) begin
        emit = 1'b1;
        nxt.skipping_leading = 1'b0;
        if (cur.component_len != 2'd3) nxt.component_len = cur.component_len + 2'd1;
        nxt.prev2_is_dot = cur.prev_is_dot;
        nxt.prev_is_dot  = (byte_in == ChDot);
      end

      // missing terminator ranks below the byte's own checks
      if (!err && last_in) begin
        err = 1'b1; err_status = ST_INVALID;
      end

      if (emit) begin
        res.out_valid     = 1'b1;
        res.out_byte      = byte_in;
        nxt.written_count = count_inc[CapWidth-1:0];
      end

      if (err) begin
        res.done_res = 1'b1;
        res.status   = err_status;
        if (last_in) nxt = rearm_state;
        else         nxt.discarding = 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/pnorm_out_reg.sv =====
// Result register between the scan logic and the output channel.
`timescale 1ns / 1ps
`default_nettype none
module pnorm_out_reg
  import pnorm_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    load,
  input  wire result_t load_data,
  input  wire logic    res_stall,
  output logic         res_valid,
  output result_t      res_data,
  output logic         busy
);

  // a full register that is not being drained blocks new loads
  assign busy = res_valid && res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_data <= load_data;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/path_normalizer_core.sv =====
// Path normalizer top level: byte-stream path cleanup with error reporting.
//
// Input channel (in_valid / in_stall) carries one path byte per transfer,
// byte 0 being the terminator and last_in marking the buffer's final byte.
// Output channel (res_valid / res_stall) returns exactly one result per
// input byte: out_valid/out_byte for an emitted byte, done_res/status when
// the path ends or an error is found.
// cfg_write_en / cfg_write_data set the output capacity (bytes, including
// the terminator); it applies from the next transferred byte.
// The result is registered: it appears in the cycle after the input transfer.
// Throughput: one byte per cycle while the output is not stalled; the scan
// state update is combinational, and the result register lets a new byte
// enter while the previous result is being taken.
// Reset: capacity returns to 512 and the scanner is armed for a new path.
// A stall on the output holds the result and raises in_stall until the
// result is taken.
`timescale 1ns / 1ps
`default_nettype none
module path_normalizer_core
  import pnorm_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [ByteWidth-1:0] byte_in,
  input  wire logic                 last_in,
  output logic                      res_valid,
  input  wire logic                 res_stall,
  output logic                      out_valid,
  output logic [ByteWidth-1:0]      out_byte,
  output logic                      done_res,
  output logic [1:0]                status,
  input  wire logic                 cfg_write_en,
  input  wire logic [CapWidth-1:0]  cfg_write_data
);

  logic [CapWidth-1:0] out_capacity;
  scan_state_t         scan;
  scan_state_t         scan_next;
  result_t             step_res;
  result_t             res_data;
  logic                accept;
  logic                busy;

  assign in_stall = busy;
  assign accept   = in_valid && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_capacity <= CapReset;
    end else if (cfg_write_en) begin
      out_capacity <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan <= ScanRearm;
    end else if (accept) begin
      scan <= scan_next;
    end
  end

  pnorm_step u_step (
    .cur      (scan),
    .byte_in  (byte_in),
    .last_in  (last_in),
    .capacity (out_capacity),
    .nxt      (scan_next),
    .res      (step_res)
  );

  pnorm_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .load_data (step_res),
    .res_stall (res_stall),
    .res_valid (res_valid),
    .res_data  (res_data),
    .busy      (busy)
  );

  assign out_valid = res_data.out_valid;
  assign out_byte  = res_data.out_byte;
  assign done_res  = res_data.done_res;
  assign status    = res_data.status;

  // an emitted byte never closes the path
  assert property (@(posedge clk) disable iff (rst)
    (res_valid && out_valid) |-> (!done_res && out_byte != ChTerm))
    else $error("emitted byte flagged done or zero");

  // status is only reported with done
  assert property (@(posedge clk) disable iff (rst)
    (res_valid && !done_res) |-> (status == ST_OK))
    else $error("status without done");

  // a transferred terminator re-arms the scanner
  assert property (@(posedge clk) disable iff (rst)
    (accept && byte_in == ChTerm) |=>
      (scan.skipping_leading && scan.written_count == '0 && !scan.discarding))
    else $error("terminator did not re-arm scanner");

  // a transfer always leaves a result pending
  assert property (@(posedge clk) disable iff (rst)
    accept |=> res_valid)
    else $error("transfer produced no result");

endmodule
`default_nettype wire

// ===== tb/path_normalizer_core_tb.sv =====
// Testbench for path_normalizer_core: directed and random byte streams checked against a predictor.
`timescale 1ns / 1ps
module path_normalizer_core_tb;
  import pnorm_pkg::*;

  localparam int unsigned CycleLimit = 400000;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  logic [ByteWidth-1:0] byte_in;
  logic                 last_in;
  logic                 res_valid;
  logic                 res_stall;
  logic                 out_valid;
  logic [ByteWidth-1:0] out_byte;
  logic                 done_res;
  logic [1:0]           status;
  logic                 cfg_write_en;
  logic [CapWidth-1:0]  cfg_write_data;

  path_normalizer_core i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .byte_in       (byte_in),
    .last_in       (last_in),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .out_valid     (out_valid),
    .out_byte      (out_byte),
    .done_res      (done_res),
    .status        (status),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data)
  );

  // Predictor state: scanner copy and configured capacity.
  scan_state_t         scan;
  logic [CapWidth-1:0] capacity;
  result_t             expected_results[$];

  int unsigned mismatch_count = 0;
  int unsigned items_sent = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_req = 0;
  int unsigned hold_left = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void rearm_scan();
    scan = '0;
    scan.skipping_leading = 1'b1;
  endfunction

  function automatic logic dot_component();
    return (scan.component_len == 2'd1 && scan.prev_is_dot) ||
           (scan.component_len == 2'd2 && scan.prev_is_dot && scan.prev2_is_dot);
  endfunction

  function automatic logic buffer_full();
    return ({1'b0, scan.written_count} + 14'd1) >= {1'b0, capacity};
  endfunction

  function automatic result_t normalize_byte(input logic [7:0] b, input logic is_last);
    result_t r;
    logic    err;
    r = '0;
    err = 1'b0;
    if (scan.discarding) begin
      if (b == ChTerm || is_last) rearm_scan();
      return r;
    end
    if (b == ChTerm) begin
      r.done_res = 1'b1;
      if (scan.skipping_leading) r.status = ST_INVALID;
      else if (scan.component_len == 2'd0 || dot_component()) r.status = ST_FORBIDDEN;
      else r.status = ST_OK;
      rearm_scan();
      return r;
    end
    if (b == ChSlash) begin
      if (scan.skipping_leading || scan.component_len == 2'd0) begin
        // leading or repeated separator: drop it
      end else if (dot_component()) begin
        err = 1'b1;
        r.status = ST_FORBIDDEN;
      end else if (buffer_full()) begin
        err = 1'b1;
        r.status = ST_TOO_LONG;
      end else if (!is_last) begin
        r.out_valid = 1'b1;
        r.out_byte = ChSlash;
        scan.written_count = scan.written_count + 1'b1;
        scan.component_len = 2'd0;
        scan.prev_is_dot = 1'b0;
        scan.prev2_is_dot = 1'b0;
      end
    end else if (b < ChSpace || b == ChDel) begin
      err = 1'b1;
      r.status = ST_INVALID;
    end else if (buffer_full()) begin
      err = 1'b1;
      r.status = ST_TOO_LONG;
    end else if (!is_last) begin
      r.out_valid = 1'b1;
      r.out_byte = b;
      scan.written_count = scan.written_count + 1'b1;
      scan.skipping_leading = 1'b0;
      if (scan.component_len != 2'd3) scan.component_len = scan.component_len + 1'b1;
      scan.prev2_is_dot = scan.prev_is_dot;
      scan.prev_is_dot = (b == ChDot);
    end
    // a last byte that raised nothing else still lacks its terminator
    if (!err && is_last) begin
      err = 1'b1;
      r.status = ST_INVALID;
    end
    if (err) begin
      r.done_res = 1'b1;
      if (is_last) rearm_scan();
      else scan.discarding = 1'b1;
    end
    return r;
  endfunction

  task automatic note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%s", msg);
  endtask

  // Track configuration and input transfers, check each result transfer.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst) begin
      capacity = CapReset;
      rearm_scan();
    end else begin
      if (cfg_write_en) capacity = cfg_write_data;
      if (in_valid && !in_stall) expected_results.push_back(normalize_byte(byte_in, last_in));
      if (res_valid === 1'b1 && !res_stall) begin
        got.out_valid = out_valid;
        got.out_byte = out_byte;
        got.done_res = done_res;
        got.status = status_t'(status);
        if (expected_results.size() == 0) begin
          note_mismatch($sformatf("unexpected result: valid %0b byte %h done %0b status %0d",
                                  out_valid, out_byte, done_res, status));
        end else begin
          want = expected_results.pop_front();
          if (got !== want)
            note_mismatch($sformatf({"mismatch: expected valid %0b byte %h done %0b status %0d,",
                                     " got valid %0b byte %h done %0b status %0d"},
                                    want.out_valid, want.out_byte, want.done_res, want.status,
                                    out_valid, out_byte, done_res, status));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver: random stall, or a long hold when one is requested.
  initial begin
    res_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        res_stall <= 1'b1;
      end else begin
        res_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Called and returns at a falling edge; in_valid stays high after the transfer.
  task automatic send_byte(input logic [7:0] b, input logic is_last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    byte_in <= b;
    last_in <= is_last;
    do @(posedge clk); while (in_stall);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s, input bit with_term);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
    if (with_term) send_byte(ChTerm, 1'b0);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_capacity(input logic [CapWidth-1:0] cap);
    wait_for_results();
    // let the result register settle before touching the register
    repeat (2) @(negedge clk);
    cfg_write_en <= 1'b1;
    cfg_write_data <= cap;
    @(negedge clk);
    cfg_write_en <= 1'b0;
  endtask

  task automatic test_normal_paths();
    send_text("", 1'b1);
    send_byte(ChSlash, 1'b0);
    send_byte(ChSlash, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_text("//b", 1'b1);
  endtask

  task automatic test_error_paths();
    send_text("./", 1'b1);
    send_text("a/..", 1'b1);
    send_text("a/", 1'b1);
    send_byte(ChDel, 1'b0);
    send_byte("x", 1'b1);
    send_byte(8'h1F, 1'b1);
    send_byte("z", 1'b1);
  endtask

  task automatic test_backpressure();
    hold_req = 200;
    for (int i = 0; i < 10; i++) send_text("abc/", 1'b0);
    send_byte("d", 1'b0);
    send_byte(ChTerm, 1'b0);
    // pause until every result is back
    wait_for_results();
    stall_pct = 64;
    send_text("x/y/zz", 1'b1);
    stall_pct = 0;
  endtask

  task automatic test_capacity_limits();
    set_capacity(CapWidth'(2));
    send_text("ab", 1'b1);
    set_capacity(CapReset);
  endtask

  task automatic send_random_path();
    int unsigned len;
    int unsigned kind;
    int unsigned pick;
    logic [7:0]  b;
    kind = $urandom_range(99);
    len = ($urandom_range(19) == 0) ? $urandom_range(80) : $urandom_range(12);
    for (int i = 0; i < len; i++) begin
      if (kind < 10) begin
        send_byte(8'($urandom_range(255)), $urandom_range(15) == 0);
        continue;
      end
      pick = $urandom_range(99);
      if (pick < 28) b = ChSlash;
      else if (pick < 45) b = ChDot;
      else if (pick < 85) b = 8'($urandom_range(8'h21, 8'h7E));
      else if (pick < 92) b = 8'($urandom_range(8'h80, 8'hFF));
      else if (pick < 95) b = ChSpace;
      else b = ($urandom_range(3) == 0) ? ChDel : 8'($urandom_range(1, 8'h1F));
      send_byte(b, 1'b0);
    end
    if (kind < 10) return;
    if (kind < 85) send_byte(ChTerm, $urandom_range(7) == 0);
    else if (kind < 95) send_byte(8'($urandom_range(1, 255)), 1'b1);
    // otherwise run straight into the next path
  endtask

  task automatic test_random_paths();
    int unsigned target;
    int          k;
    logic [CapWidth-1:0] cap;
    k = 0;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 64; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 64; end
        default: begin send_idle_pct = 8; stall_pct = 8; end
      endcase
      repeat (3) begin
        case (k)
          0: cap = CapWidth'(2);
          1: cap = CapWidth'(4096);
          2: cap = CapWidth'(3);
          3: cap = CapWidth'(0);
          4: cap = CapWidth'(8191);
          5: cap = CapWidth'(1);
          6: cap = CapWidth'(16);
          7: cap = CapWidth'(512);
          8: cap = CapWidth'(5);
          9: cap = CapWidth'(40);
          10: cap = CapWidth'(4);
          default: cap = CapWidth'($urandom_range(2, 4096));
        endcase
        k++;
        set_capacity(cap);
        target = items_sent + 140;
        while (items_sent < target) send_random_path();
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    byte_in = '0;
    last_in = 1'b0;
    cfg_write_en = 1'b0;
    cfg_write_data = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_normal_paths();
    test_error_paths();
    test_backpressure();
    test_capacity_limits();
    test_random_paths();
    wait_for_results();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/pnorm_pkg.sv
rtl/core/pnorm_step.sv
rtl/core/pnorm_out_reg.sv
rtl/core/path_normalizer_core.sv
tb/path_normalizer_core_tb.sv
